[rtl/dual_token_bucket_policer_top_defines.svh]
// Assertion macros for the dual token bucket policer.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DUAL_TOKEN_BUCKET_POLICER_TOP_DEFINES_SVH
`define DUAL_TOKEN_BUCKET_POLICER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DTBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtbp check failed");

// Next-cycle implication, disabled while reset is asserted
`define DTBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtbp check failed");

`endif

[rtl/dtbp_pkg.sv]
// Shared constants and types for the dual token bucket policer.
// No dependencies; used by dtbp_engine and the top level.
package dtbp_pkg;

    localparam int HOST_SLOTS = 1024;
    localparam int HOST_W     = $clog2(HOST_SLOTS);
    localparam int METERS     = 2;
    localparam int ENTRIES    = METERS * HOST_SLOTS;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_M0_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_M0_CAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M0_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M1_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_M1_CAP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_M1_LEVEL = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] cap;
        logic [DATA_W-1:0] level;
    } t_meter_cfg;

    typedef struct packed {
        logic [HOST_W-1:0] host;
        logic              byte_meter;
        logic              packet_meter;
        logic [DATA_W-1:0] byte_weight;
        logic [DATA_W-1:0] packet_cost;
        logic [LEN_W-1:0]  length_bytes;
        logic [DATA_W-1:0] now_msec;
    } t_job;

    typedef struct packed {
        logic byte_conform;
        logic packet_conform;
    } t_verdict;

endpackage

[rtl/dual_token_bucket_policer_top.sv]
// Sequence: the engine forms the byte cost, then reads, loads, refills, charges and
// checks each charged bucket in turn (byte, then packet); the result is registered.
// Throughput: one item at a time, accepted only while the engine is idle; the
// single-port bucket memory and the one shared 32x32 multiplier serve every bucket update.
// Reset: synchronous; the 2048-entry bucket store is zeroed one entry a cycle,
// and the input is not ready until clearing ends (config writes accepted).
module dual_token_bucket_policer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dtbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dtbp_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [9:0]                         i_host_index,
    input  logic                               i_byte_meter,
    input  logic                               i_packet_meter,
    input  logic [31:0]                        i_byte_weight,
    input  logic [31:0]                        i_packet_cost,
    input  logic [15:0]                        i_length_bytes,
    input  logic [31:0]                        i_now_msec,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_byte_conform,
    output logic                               o_packet_conform,
    output logic                               o_accept
);

    dtbp_pkg::t_meter_cfg [dtbp_pkg::METERS-1:0] r_cfg;
    dtbp_pkg::t_job                              job;
    dtbp_pkg::t_verdict                          res;
    logic                                        eng_idle;
    logic                                        eng_done;
    logic                                        res_ready;
    logic                                        r_out_valid;
    dtbp_pkg::t_verdict                          r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dtbp_pkg::CFG_M0_RATE:  r_cfg[0].rate  <= i_cfg_data;
                dtbp_pkg::CFG_M0_CAP:   r_cfg[0].cap   <= i_cfg_data;
                dtbp_pkg::CFG_M0_LEVEL: r_cfg[0].level <= i_cfg_data;
                dtbp_pkg::CFG_M1_RATE:  r_cfg[1].rate  <= i_cfg_data;
                dtbp_pkg::CFG_M1_CAP:   r_cfg[1].cap   <= i_cfg_data;
                dtbp_pkg::CFG_M1_LEVEL: r_cfg[1].level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign job.host         = i_host_index[dtbp_pkg::HOST_W-1:0];
    assign job.byte_meter   = i_byte_meter;
    assign job.packet_meter = i_packet_meter;
    assign job.byte_weight  = i_byte_weight;
    assign job.packet_cost  = i_packet_cost;
    assign job.length_bytes = i_length_bytes;
    assign job.now_msec     = i_now_msec;

    assign o_in_ready = eng_idle;
    assign res_ready  = !r_out_valid || i_out_ready;

    dtbp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && eng_idle),
        .i_job       (job),
        .i_cfg       (r_cfg),
        .i_res_ready (res_ready),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_conform   = r_out.byte_conform;
    assign o_packet_conform = r_out.packet_conform;
    assign o_accept         = r_out.byte_conform & r_out.packet_conform;

endmodule

[rtl/dtbp_engine.sv]
// Bucket store, shared 32x32 multiplier and sequencer of the policer.
// Depends on dtbp_pkg and dual_token_bucket_policer_top_defines.svh.
`include "dual_token_bucket_policer_top_defines.svh"

module dtbp_engine (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  dtbp_pkg::t_job                             i_job,
    input  dtbp_pkg::t_meter_cfg [dtbp_pkg::METERS-1:0] i_cfg,
    input  logic                                       i_res_ready,
    output logic                                       o_idle,
    output logic                                       o_done,
    output dtbp_pkg::t_verdict                         o_res
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_BMUL  = 11'b000_0000_0100,
        S_BSAT  = 11'b000_0000_1000,
        S_RD    = 11'b000_0001_0000,
        S_LOAD  = 11'b000_0010_0000,
        S_MUL   = 11'b000_0100_0000,
        S_ADD   = 11'b000_1000_0000,
        S_SUB   = 11'b001_0000_0000,
        S_CHK   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    localparam int W = dtbp_pkg::DATA_W;

    t_state                        r_state, n_state;
    logic                          r_pkt, n_pkt;
    logic [dtbp_pkg::SLOT_W-1:0]   r_clr;
    dtbp_pkg::t_job                r_job;
    logic [W-1:0]                  r_bcost;
    logic [W-1:0]                  r_tok;
    logic [W-1:0]                  r_dt;
    logic [2*W-1:0]                r_prod;
    logic                          r_bok;
    logic                          r_pok;

    logic [2*W-1:0]                r_mem [0:dtbp_pkg::ENTRIES-1];
    logic [2*W-1:0]                r_rd;

    logic                          meter;
    dtbp_pkg::t_meter_cfg          mcfg;
    logic [W-1:0]                  cost;
    logic [dtbp_pkg::SLOT_W-1:0]   slot;
    logic [dtbp_pkg::SLOT_W-1:0]   mem_addr;
    logic                          mem_we;
    logic [2*W-1:0]                mem_wdata;
    logic [W-1:0]                  mul_a;
    logic [W-1:0]                  mul_b;
    logic [2*W-1:0]                mul_p;
    logic [W-1:0]                  prod_sat;
    logic [W:0]                    sum;
    logic [W-1:0]                  sum_sat;
    logic [W-1:0]                  refill;
    logic [W-1:0]                  paid;
    logic                          pass;

    assign meter    = r_pkt ? r_job.packet_meter : r_job.byte_meter;
    assign mcfg     = i_cfg[meter];
    assign cost     = r_pkt ? r_job.packet_cost : r_bcost;
    assign slot     = {r_job.host, meter};

    // shared multiplier: length x weight, then elapsed x rate
    assign mul_a    = (r_state == S_BMUL) ? {{(W - dtbp_pkg::LEN_W){1'b0}}, r_job.length_bytes}
                                          : r_dt;
    assign mul_b    = (r_state == S_BMUL) ? r_job.byte_weight : mcfg.rate;
    assign mul_p    = mul_a * mul_b;
    assign prod_sat = (|r_prod[2*W-1:W]) ? {W{1'b1}} : r_prod[W-1:0];

    assign sum      = {1'b0, r_tok} + {1'b0, prod_sat};
    assign sum_sat  = sum[W] ? {W{1'b1}} : sum[W-1:0];
    assign refill   = (sum_sat > mcfg.cap) ? mcfg.cap : sum_sat;
    assign paid     = (r_tok > cost) ? (r_tok - cost) : '0;
    assign pass     = r_tok > mcfg.level;

    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_SUB);
    assign mem_addr  = (r_state == S_CLEAR) ? r_clr : slot;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : {r_job.now_msec, paid};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_addr];
    end

    always_comb begin
        n_state = r_state;
        n_pkt   = r_pkt;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == dtbp_pkg::SLOT_W'(dtbp_pkg::ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_BMUL;
                end
            end
            S_BMUL: n_state = S_BSAT;
            S_BSAT: begin
                if (prod_sat != '0) begin
                    n_pkt   = 1'b0;
                    n_state = S_RD;
                end else if (r_job.packet_cost != '0) begin
                    n_pkt   = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD:   n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_SUB;
            S_SUB:  n_state = S_CHK;
            S_CHK: begin
                if (!r_pkt && (r_job.packet_cost != '0)) begin
                    n_pkt   = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pkt   <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_pkt   <= n_pkt;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + dtbp_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_BMUL: begin
                r_prod <= mul_p;
            end
            S_BSAT: begin
                r_bcost <= prod_sat;
                r_bok   <= 1'b1;
                r_pok   <= 1'b1;
            end
            S_LOAD: begin
                r_tok <= r_rd[W-1:0];
                r_dt  <= r_job.now_msec - r_rd[2*W-1:W];
            end
            S_MUL: begin
                r_prod <= mul_p;
            end
            S_ADD: begin
                if (r_dt != '0) begin
                    r_tok <= refill;
                end
            end
            S_SUB: begin
                r_tok <= paid;
            end
            S_CHK: begin
                if (r_pkt) begin
                    r_pok <= pass;
                end else begin
                    r_bok <= pass;
                end
            end
            default: ;
        endcase
    end

    assign o_idle              = (r_state == S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_res.byte_conform   = r_bok;
    assign o_res.packet_conform = r_pok;

    `DTBP_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE)
    `DTBP_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && !i_res_ready, (r_state == S_DONE) && $stable(o_res))
    `DTBP_ASSERT_NEXT(a_no_elapsed, i_clk, i_rst_n, (r_state == S_ADD) && (r_dt == '0), $stable(r_tok))
    `DTBP_ASSERT_NEXT(a_pkt_last, i_clk, i_rst_n, (r_state == S_CHK) && r_pkt, r_state == S_DONE)
    `DTBP_ASSERT_NEXT(a_sub_chk, i_clk, i_rst_n, r_state == S_SUB, (r_state == S_CHK) && $stable(r_pkt))

endmodule
